>>> hw/rtl/fseq_pkg.sv
// Package for the flap sensor event qualifier: request, response and
// configuration types, event codes and register indexes. No dependencies.
`default_nettype none

package fseq_pkg;

   // Field widths fixed by the interface
   localparam int LEVEL_BITS     = 7;
   localparam int SENSOR_BITS    = 3;
   localparam int KIND_BITS      = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int COUNT_BITS     = 16;

   // Response queue depth (power of two, room for two results per tick)
   localparam int RSP_FIFO_DEPTH = 4;

   // Event kinds
   localparam logic [KIND_BITS-1:0] KIND_IR        = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_VIBRATION = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_BLOCKADE  = 2'd2;

   // Sensor code meaning no sensor latched
   localparam logic [SENSOR_BITS-1:0] NO_SENSOR = 3'd7;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IR_DEBOUNCE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VIB_DEBOUNCE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCKADE_THR = 2'd2;

   // Reset values of the configuration registers
   localparam logic [CSR_DATA_BITS-1:0] IR_DEBOUNCE_RESET  = 16'd50;
   localparam logic [CSR_DATA_BITS-1:0] VIB_DEBOUNCE_RESET = 16'd50;
   localparam logic [CSR_DATA_BITS-1:0] BLOCKADE_THR_RESET = 16'd10;

   typedef struct packed {
      logic                  ir_edge;
      logic [LEVEL_BITS-1:0] ir_levels;
      logic                  vibration_change;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   event_kind;
      logic [SENSOR_BITS-1:0] sensor_index;
      logic                   last_of_tick;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] ir_debounce_ms;
      logic [CSR_DATA_BITS-1:0] vibration_debounce_ms;
      logic [CSR_DATA_BITS-1:0] blockade_threshold;
   } cfg_type;

   // Results of one tick handed to the response queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

>>> hw/rtl/fseq_csr.sv
// Configuration registers of the flap sensor event qualifier.
// Depends on fseq_pkg.
`default_nettype none

module fseq_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [fseq_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [fseq_pkg::CSR_DATA_BITS-1:0]     csr_wr_data,
   output fseq_pkg::cfg_type                           cfg
);

   fseq_pkg::cfg_type cfg_ff;
   fseq_pkg::cfg_type cfg_in;

   // Decode the write; an unused index leaves everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fseq_pkg::CSR_IR_DEBOUNCE:  cfg_in.ir_debounce_ms        = csr_wr_data;
            fseq_pkg::CSR_VIB_DEBOUNCE: cfg_in.vibration_debounce_ms = csr_wr_data;
            fseq_pkg::CSR_BLOCKADE_THR: cfg_in.blockade_threshold    = csr_wr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ir_debounce_ms        <= fseq_pkg::IR_DEBOUNCE_RESET;
         cfg_ff.vibration_debounce_ms <= fseq_pkg::VIB_DEBOUNCE_RESET;
         cfg_ff.blockade_threshold    <= fseq_pkg::BLOCKADE_THR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fseq_core.sv
// Per-tick qualification logic: time counter, sensor latch, debounce checks
// and vibration counting. Depends on fseq_pkg.
`default_nettype none

module fseq_core #(
   parameter int SENSORS   = 7,
   parameter int TIME_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  fseq_pkg::req_type       req,
   input  fseq_pkg::cfg_type       cfg,
   output fseq_pkg::push_type      push
);

   logic [TIME_BITS-1:0]               now_ff, now_in;
   logic [TIME_BITS-1:0]               last_ir_ff, last_ir_in;
   logic [TIME_BITS-1:0]               last_vib_ff, last_vib_in;
   logic [fseq_pkg::SENSOR_BITS-1:0]   current_sensor_ff, current_sensor_in;
   logic [fseq_pkg::SENSOR_BITS-1:0]   reported_sensor_ff, reported_sensor_in;
   logic                               vib_pending_ff, vib_pending_in;
   logic [fseq_pkg::COUNT_BITS-1:0]    vib_count_ff, vib_count_in;

   logic [fseq_pkg::SENSOR_BITS-1:0]   lowest_sensor;
   logic                               any_level;
   logic                               pending;
   logic [TIME_BITS-1:0]               ir_elapsed;
   logic [TIME_BITS-1:0]               vib_elapsed;
   logic                               ir_fire;
   logic                               vib_fire;
   logic                               blockade;
   logic [fseq_pkg::COUNT_BITS-1:0]    count_mid;
   fseq_pkg::rsp_type                  ir_rsp;
   fseq_pkg::rsp_type                  vib_rsp;

   // Lowest-numbered high level among the sensors in use
   always_comb begin
      lowest_sensor = fseq_pkg::NO_SENSOR;
      any_level     = 1'b0;
      for (int i = SENSORS - 1; i >= 0; i--) begin
         if (req.ir_levels[i]) begin
            lowest_sensor = fseq_pkg::SENSOR_BITS'(i);
            any_level     = 1'b1;
         end
      end
   end

   // Tick update and debounce checks
   always_comb begin
      now_in            = now_ff + TIME_BITS'(1);
      current_sensor_in = (req.ir_edge && any_level) ? lowest_sensor : current_sensor_ff;
      pending           = vib_pending_ff | req.vibration_change;

      // IR check: elapsed time is taken modulo the counter width
      ir_elapsed = now_in - last_ir_ff;
      ir_fire    = (ir_elapsed > TIME_BITS'(cfg.ir_debounce_ms)) &&
                   (current_sensor_in != reported_sensor_ff);
      count_mid  = ir_fire ? '0 : vib_count_ff;

      // Vibration check sees the count after a same-tick IR clear
      vib_elapsed = now_in - last_vib_ff;
      vib_fire    = (vib_elapsed > TIME_BITS'(cfg.vibration_debounce_ms)) && pending;
      blockade    = count_mid > cfg.blockade_threshold;

      last_ir_in         = ir_fire ? now_in : last_ir_ff;
      reported_sensor_in = ir_fire ? current_sensor_in : reported_sensor_ff;
      last_vib_in        = vib_fire ? now_in : last_vib_ff;
      vib_pending_in     = vib_fire ? 1'b0 : pending;
      if (vib_fire && (count_mid != {fseq_pkg::COUNT_BITS{1'b1}}))
         vib_count_in = count_mid + fseq_pkg::COUNT_BITS'(1);
      else
         vib_count_in = count_mid;
   end

   // Result items of this tick, IR event first
   always_comb begin
      ir_rsp.event_kind    = fseq_pkg::KIND_IR;
      ir_rsp.sensor_index  = current_sensor_in;
      ir_rsp.last_of_tick  = ~vib_fire;
      vib_rsp.event_kind   = blockade ? fseq_pkg::KIND_BLOCKADE : fseq_pkg::KIND_VIBRATION;
      vib_rsp.sensor_index = '0;
      vib_rsp.last_of_tick = 1'b1;

      push.count  = accept ? ({1'b0, ir_fire} + {1'b0, vib_fire}) : 2'd0;
      push.first  = ir_fire ? ir_rsp : vib_rsp;
      push.second = vib_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff             <= '0;
         last_ir_ff         <= '0;
         last_vib_ff        <= '0;
         current_sensor_ff  <= fseq_pkg::NO_SENSOR;
         reported_sensor_ff <= fseq_pkg::NO_SENSOR;
         vib_pending_ff     <= 1'b0;
         vib_count_ff       <= '0;
      end else if (accept) begin
         now_ff             <= now_in;
         last_ir_ff         <= last_ir_in;
         last_vib_ff        <= last_vib_in;
         current_sensor_ff  <= current_sensor_in;
         reported_sensor_ff <= reported_sensor_in;
         vib_pending_ff     <= vib_pending_in;
         vib_count_ff       <= vib_count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/fseq_rsp_fifo.sv
// Response queue: takes up to two results per cycle, hands out one.
// Raises 'full' while fewer than two places are free. Depends on fseq_pkg.
`default_nettype none

module fseq_rsp_fifo (
   input  wire logic          clock,
   input  wire logic          reset,
   input  fseq_pkg::push_type push,
   output logic               full,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output fseq_pkg::rsp_type  rsp_payload
);

   localparam int DEPTH    = fseq_pkg::RSP_FIFO_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   fseq_pkg::rsp_type    entry_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [PTR_BITS-1:0]  wr_ptr_next;
   logic                 pop;

   assign pop         = (count_ff != '0) && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + PTR_BITS'(1);

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = pop ? (rd_ptr_ff + PTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push.count != 2'd0)
         entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2)
         entry_ff[wr_ptr_next] <= push.second;
   end

   assign full        = count_ff > CNT_BITS'(DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

>>> hw/rtl/flap_sensor_event_qualifier_top.sv
// Flap sensor event qualifier, top level.
// Depends on fseq_pkg, fseq_csr, fseq_core and fseq_rsp_fifo.
//
// Usage:
//   Each request on the req_ channel is one millisecond tick carrying the IR
//   edge flag, the IR pin levels and the vibration change flag. A request is
//   taken at a clock edge with req_valid high and req_stall low.
//   Each tick gives zero, one or two responses on the rsp_ channel (IR event
//   first, then vibration or blockade); last_of_tick marks the final one.
//   A response is stored in the queue when its request is taken and is offered
//   on rsp_valid once those ahead of it have left. Throughput: one request per
//   cycle while the four-entry queue has room for two results; responses leave
//   at one per cycle unless stalled, so back-to-back two-result ticks fill the queue.
//   When the receiver holds rsp_stall, responses wait in the queue and
//   req_stall rises once fewer than two places are free.
//   The csr_ port writes a debounce or threshold register; write only while
//   no request is in flight.
//   Reset (synchronous) restores default settings, clears the time counter,
//   the sensor latches, the vibration state and empties the queue.
`default_nettype none

module flap_sensor_event_qualifier_top #(
   parameter int SENSORS   = 7,
   parameter int TIME_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  fseq_pkg::req_type                        req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output fseq_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_wr_en,
   input  wire logic [fseq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [fseq_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   fseq_pkg::cfg_type  cfg;
   fseq_pkg::push_type push;
   logic               full;
   logic               accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   fseq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   fseq_core #(
      .SENSORS   (SENSORS),
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg),
      .push   (push)
   );

   fseq_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> test/flap_sensor_event_qualifier_top_tb.sv
// Self-checking testbench for flap_sensor_event_qualifier_top: predicts the IR,
// vibration and blockade events of every tick and checks each response in order.
// Depends on fseq_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module flap_sensor_event_qualifier_top_tb;

   localparam int SENSORS      = 7;
   localparam int TIME_BITS    = 32;
   localparam int GAP_MAX      = 10;
   localparam int SETTLE_TICKS = 4;
   localparam int PHASES       = 8;
   localparam int PHASE_TICKS  = 228;
   localparam logic [fseq_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   fseq_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fseq_pkg::rsp_type rsp_payload;
   logic              csr_wr_en = 1'b0;
   logic [fseq_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [fseq_pkg::CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   // Idling switches for each side
   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;

   int fail_count = 0;

   // Shadow of the qualifier state and registers
   fseq_pkg::cfg_type        csr_shadow = {fseq_pkg::IR_DEBOUNCE_RESET,
                                           fseq_pkg::VIB_DEBOUNCE_RESET,
                                           fseq_pkg::BLOCKADE_THR_RESET};
   logic [TIME_BITS-1:0]     tick_ms = '0;
   logic [TIME_BITS-1:0]     last_ir_ms = '0;
   logic [TIME_BITS-1:0]     last_vib_ms = '0;
   logic [fseq_pkg::SENSOR_BITS-1:0] latched_sensor = fseq_pkg::NO_SENSOR;
   logic [fseq_pkg::SENSOR_BITS-1:0] reported_sensor = fseq_pkg::NO_SENSOR;
   bit                       vib_pending = 1'b0;
   logic [fseq_pkg::COUNT_BITS-1:0]  vib_count = '0;

   fseq_pkg::rsp_type due_events[$];
   fseq_pkg::rsp_type oldest_event;

   flap_sensor_event_qualifier_top #(
      .SENSORS(SENSORS),
      .TIME_BITS(TIME_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("[flap_sensor_event_qualifier_top] ERROR");
      $finish;
   end

   // One millisecond tick of the qualifier: queues the events it reports
   task automatic qualify_tick(input fseq_pkg::req_type r);
      logic [TIME_BITS-1:0] ir_elapsed;
      logic [TIME_BITS-1:0] vib_elapsed;
      fseq_pkg::rsp_type ir_ev;
      fseq_pkg::rsp_type vib_ev;
      bit have_ir;
      bit have_vib;
      bit found;
      have_ir  = 1'b0;
      have_vib = 1'b0;
      found    = 1'b0;
      tick_ms  = tick_ms + 1'b1;
      // lowest high level wins; no level keeps the old sensor
      if (r.ir_edge) begin
         for (int i = 0; i < SENSORS; i++) begin
            if (!found && r.ir_levels[i]) begin
               latched_sensor = fseq_pkg::SENSOR_BITS'(i);
               found = 1'b1;
            end
         end
      end
      if (r.vibration_change)
         vib_pending = 1'b1;
      ir_elapsed = tick_ms - last_ir_ms;
      if (ir_elapsed > TIME_BITS'(csr_shadow.ir_debounce_ms)
          && latched_sensor != reported_sensor) begin
         ir_ev.event_kind   = fseq_pkg::KIND_IR;
         ir_ev.sensor_index = latched_sensor;
         have_ir            = 1'b1;
         vib_count          = '0;
         last_ir_ms         = tick_ms;
         reported_sensor    = latched_sensor;
      end
      vib_elapsed = tick_ms - last_vib_ms;
      if (vib_elapsed > TIME_BITS'(csr_shadow.vibration_debounce_ms) && vib_pending) begin
         vib_ev.event_kind   = (vib_count > csr_shadow.blockade_threshold) ?
                               fseq_pkg::KIND_BLOCKADE : fseq_pkg::KIND_VIBRATION;
         vib_ev.sensor_index = '0;
         vib_ev.last_of_tick = 1'b1;
         have_vib            = 1'b1;
         if (vib_count != {fseq_pkg::COUNT_BITS{1'b1}})
            vib_count = vib_count + 1'b1;
         last_vib_ms = tick_ms;
         vib_pending = 1'b0;
      end
      if (have_ir) begin
         ir_ev.last_of_tick = !have_vib;
         due_events.push_back(ir_ev);
      end
      if (have_vib)
         due_events.push_back(vib_ev);
   endtask

   // Prediction on each accepted request, then check of each accepted response
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            qualify_tick(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (due_events.size() == 0) begin
               $error("unexpected response: kind %0d sensor %0d last %0d",
                      rsp_payload.event_kind, rsp_payload.sensor_index,
                      rsp_payload.last_of_tick);
               fail_count++;
            end else begin
               oldest_event = due_events.pop_front();
               if (rsp_payload.event_kind !== oldest_event.event_kind) begin
                  $error("event_kind: expected %0d, got %0d",
                         oldest_event.event_kind, rsp_payload.event_kind);
                  fail_count++;
               end
               if (rsp_payload.sensor_index !== oldest_event.sensor_index) begin
                  $error("sensor_index: expected %0d, got %0d",
                         oldest_event.sensor_index, rsp_payload.sensor_index);
                  fail_count++;
               end
               if (rsp_payload.last_of_tick !== oldest_event.last_of_tick) begin
                  $error("last_of_tick: expected %0d, got %0d",
                         oldest_event.last_of_tick, rsp_payload.last_of_tick);
                  fail_count++;
               end
            end
         end
      end
   end

   // Receiver: holds rsp_stall for a random gap before taking each response while rsp_gaps_on is set
   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         hold = rsp_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
         repeat (hold) @(negedge clock) rsp_stall = 1'b1;
         @(negedge clock) rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Send one tick request, after a random gap while req_gaps_on is set; returns once it is accepted
   task automatic send_tick(input fseq_pkg::req_type r);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         @(negedge clock) req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_payload = r;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_fields(input bit ir_edge,
                              input logic [fseq_pkg::LEVEL_BITS-1:0] levels,
                              input bit vib);
      fseq_pkg::req_type r;
      r.ir_edge          = ir_edge;
      r.ir_levels        = levels;
      r.vibration_change = vib;
      send_tick(r);
   endtask

   // Hold off requests until every predicted event has come out
   task automatic wait_for_quiet;
      @(negedge clock) req_valid = 1'b0;
      while (due_events.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Register write; only called while the block is idle
   task automatic write_register(input logic [fseq_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [fseq_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      @(negedge clock) csr_wr_en = 1'b0;
      case (idx)
         fseq_pkg::CSR_IR_DEBOUNCE:  csr_shadow.ir_debounce_ms        = value;
         fseq_pkg::CSR_VIB_DEBOUNCE: csr_shadow.vibration_debounce_ms = value;
         fseq_pkg::CSR_BLOCKADE_THR: csr_shadow.blockade_threshold    = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [fseq_pkg::CSR_DATA_BITS-1:0] ir_db,
                            input logic [fseq_pkg::CSR_DATA_BITS-1:0] vib_db,
                            input logic [fseq_pkg::CSR_DATA_BITS-1:0] thr);
      write_register(fseq_pkg::CSR_IR_DEBOUNCE, ir_db);
      write_register(fseq_pkg::CSR_VIB_DEBOUNCE, vib_db);
      write_register(fseq_pkg::CSR_BLOCKADE_THR, thr);
   endtask

   // Defaults after reset: both events first appear after 51 ticks
   task automatic test_reset_defaults;
      send_fields(1'b1, 7'b0000100, 1'b1);
      repeat (51) send_fields(1'b0, '0, 1'b0);
      wait_for_quiet;
   endtask

   // Sensor latch: lowest level wins, empty edge keeps the sensor, no edge no latch
   task automatic test_sensor_latch;
      write_all('0, '0, '0);
      send_fields(1'b1, 7'h40, 1'b1);
      send_fields(1'b1, 7'h7F, 1'b0);
      send_fields(1'b1, 7'h00, 1'b1);
      send_fields(1'b0, 7'h02, 1'b0);
      send_fields(1'b1, 7'h02, 1'b1);
      send_fields(1'b1, 7'h10, 1'b1);
      send_fields(1'b1, 7'h08, 1'b0);
      send_fields(1'b1, 7'h20, 1'b1);
      send_fields(1'b1, 7'h04, 1'b0);
      send_fields(1'b1, 7'h06, 1'b1);
      wait_for_quiet;
   endtask

   // IR event in the same tick clears the count before the vibration check
   task automatic test_both_events_in_tick;
      write_register(fseq_pkg::CSR_BLOCKADE_THR, 16'd1);
      repeat (3) send_fields(1'b0, 7'h00, 1'b1);
      send_fields(1'b1, 7'h20, 1'b1);
      send_fields(1'b1, 7'h20, 1'b1);
      send_fields(1'b1, 7'h01, 1'b0);
      wait_for_quiet;
   endtask

   // Writes to the spare index change nothing
   task automatic test_unused_register;
      write_register(CSR_UNUSED, 16'hFFFF);
      send_fields(1'b1, 7'h08, 1'b1);
      send_fields(1'b0, 7'h00, 1'b1);
      send_fields(1'b1, 7'h01, 1'b1);
      send_fields(1'b0, 7'h00, 1'b1);
      wait_for_quiet;
   endtask

   // Widest debounce and threshold: no events within a few ticks
   task automatic test_long_debounce;
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_fields(1'b1, 7'h40, 1'b1);
      send_fields(1'b1, 7'h02, 1'b1);
      send_fields(1'b0, 7'h7F, 1'b0);
      send_fields(1'b1, 7'h00, 1'b1);
      wait_for_quiet;
   endtask

   function automatic logic [fseq_pkg::CSR_DATA_BITS-1:0] pick_debounce;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3: return 16'd50;
         default: return fseq_pkg::CSR_DATA_BITS'($urandom_range(2, 12));
      endcase
   endfunction

   function automatic logic [fseq_pkg::CSR_DATA_BITS-1:0] pick_threshold;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 16'hFFFF;
         default: return fseq_pkg::CSR_DATA_BITS'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [fseq_pkg::LEVEL_BITS-1:0] random_levels;
      case ($urandom_range(0, 3))
         0: return '0;
         1: return fseq_pkg::LEVEL_BITS'(1 << $urandom_range(0, SENSORS - 1));
         2: return fseq_pkg::LEVEL_BITS'($urandom_range(0, 127));
         default: return fseq_pkg::LEVEL_BITS'($urandom_range(0, 127)) & 7'h70;
      endcase
   endfunction

   // Random ticks in phases, each with fresh settings and its own choice of idling
   task automatic test_random_ticks;
      for (int phase = 0; phase < PHASES; phase++) begin
         write_all(pick_debounce(), pick_debounce(), pick_threshold());
         if ($urandom_range(0, 3) == 0) begin
            req_gaps_on = 1'b0;
            rsp_gaps_on = 1'b0;
         end else begin
            req_gaps_on = $urandom_range(0, 3) != 0;
            rsp_gaps_on = $urandom_range(0, 3) != 0;
         end
         for (int n = 0; n < PHASE_TICKS; n++) begin
            if (n == PHASE_TICKS / 2 && (phase == 0 || $urandom_range(0, 1) == 1))
               wait_for_quiet;
            send_fields($urandom_range(0, 2) == 0, random_levels(),
                        $urandom_range(0, 3) == 0);
         end
         wait_for_quiet;
      end
   endtask

   initial begin
      wait (reset == 1'b0);
      test_reset_defaults;
      test_sensor_latch;
      test_both_events_in_tick;
      test_unused_register;
      test_long_debounce;
      test_random_ticks;
      wait_for_quiet;
      if (fail_count == 0)
         $display("[flap_sensor_event_qualifier_top] OK");
      else
         $display("[flap_sensor_event_qualifier_top] ERROR");
      $finish;
   end

endmodule
